// ===== src/pf_pkg.sv =====
// Shared constants for the trial-division factorization block.
`timescale 1ns / 1ps
`default_nettype none

package pf_pkg;

    localparam int VALUE_WIDTH_DEF = 31;
    localparam int FIRST_DIVISOR   = 2;

endpackage

`default_nettype wire

// ===== src/prime_factorization.sv =====
// Top level of the trial-division integer factorization block.
//
// Pulse start with value while busy is low; busy rises on the next cycle and stays high until
// the final factor is reported. Factors come out in ascending order, repeated per multiplicity,
// each on factor for exactly one cycle with valid high; the receiver cannot stall, so every
// strobe must be taken when it appears. The final result carries last. An input of 0 or 1
// gives one result with empty_res and last set, in the cycle after start, and busy never rises.
// Trial divisors are tried one at a time on the shared bit-serial divider, so the work per item
// grows with the largest divisor tried and the number of factors; the largest divisor tried is
// bounded by roughly sqrt(value).
`timescale 1ns / 1ps
`default_nettype none

module prime_factorization #(
    parameter int VALUE_WIDTH = pf_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output logic                        valid,
    output logic [VALUE_WIDTH-1:0]      factor,
    output logic                        last,
    output logic                        empty_res
);

    localparam logic [VALUE_WIDTH-1:0] FIRST_DIV = VALUE_WIDTH'(pf_pkg::FIRST_DIVISOR);

    typedef enum logic {
        S_IDLE,
        S_WAIT
    } state_t;

    state_t                 state_reg,  state_next;
    logic [VALUE_WIDTH-1:0] rem_reg,    rem_next;
    logic [VALUE_WIDTH-1:0] div_reg,    div_next;
    logic                   valid_reg,  valid_next;
    logic [VALUE_WIDTH-1:0] factor_reg, factor_next;
    logic                   last_reg,   last_next;
    logic                   empty_reg,  empty_next;

    logic                   go;
    logic [VALUE_WIDTH-1:0] go_dividend;
    logic [VALUE_WIDTH-1:0] go_divisor;
    logic                   dv_done;
    logic [VALUE_WIDTH-1:0] dv_quo;
    logic [VALUE_WIDTH-1:0] dv_rem;

    pf_div #(
        .W (VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .dividend  (go_dividend),
        .divisor   (go_divisor),
        .done      (dv_done),
        .quotient  (dv_quo),
        .remainder (dv_rem)
    );

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        valid_next  = 1'b0;
        factor_next = factor_reg;
        last_next   = 1'b0;
        empty_next  = 1'b0;
        go          = 1'b0;
        go_dividend = rem_reg;
        go_divisor  = div_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (value < FIRST_DIV)
                    begin
                        valid_next  = 1'b1;
                        factor_next = '0;
                        last_next   = 1'b1;
                        empty_next  = 1'b1;
                    end
                    else
                    begin
                        rem_next    = value;
                        div_next    = FIRST_DIV;
                        go          = 1'b1;
                        go_dividend = value;
                        go_divisor  = FIRST_DIV;
                        state_next  = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                if (dv_done)
                begin
                    priority if (div_reg > dv_quo)
                    begin
                        valid_next  = 1'b1;
                        factor_next = rem_reg;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (dv_rem == '0)
                    begin
                        valid_next  = 1'b1;
                        factor_next = div_reg;
                        rem_next    = dv_quo;
                        go          = 1'b1;
                        go_dividend = dv_quo;
                    end
                    else
                    begin
                        div_next   = div_reg + 1'b1;
                        go         = 1'b1;
                        go_divisor = div_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            empty_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        factor_reg <= factor_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign valid     = valid_reg;
    assign factor    = factor_reg;
    assign last      = last_reg;
    assign empty_res = empty_reg;

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> busy)
        else $error("non-final transfer while idle");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |-> !busy)
        else $error("final transfer while still busy");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        valid && empty_res |-> last && (factor == '0))
        else $error("empty result malformed");

    a_factor_min: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !empty_res |-> factor >= FIRST_DIV)
        else $error("factor below two");

    a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
        busy && $past(busy) |-> div_reg >= $past(div_reg))
        else $error("trial divisor went backward");

endmodule

`default_nettype wire

// ===== src/pf_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pf_div #(
    parameter int W = pf_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         go,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int CW = $clog2(W);

    logic          run_reg,  run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic [W-1:0]  acc_reg,  acc_next;
    logic [W-1:0]  quo_reg,  quo_next;
    logic [W-1:0]  dsr_reg,  dsr_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    always_comb
    begin
        trial     = {acc_reg, quo_reg[W-1]};
        diff      = trial - {1'b0, dsr_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            acc_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            if (diff[W])
            begin
                acc_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            else
            begin
                acc_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = acc_reg;

endmodule

`default_nettype wire
